FILE: rtl/nsfl_pkg.sv
// ----------------------------------------------------------------------------
// nsfl_pkg: shared types and constants of the NMEA sentence field locator
// Holds the event codes, the parser phase encoding, register indexes and
// the packing of the result item.
// ----------------------------------------------------------------------------
package nsfl_pkg;

   // Longest sentence type that can be matched
   localparam int MAX_TYPE_CHARS = 6;

   // Characters of interest
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   // Register indexes on the csr channel
   localparam logic CSR_TYPE_CHARS  = 1'b0;
   localparam logic CSR_TYPE_LENGTH = 1'b1;

   localparam logic [2:0]  TYPE_LENGTH_RESET = 3'd5;
   localparam logic [47:0] TYPE_CHARS_RESET  = 48'd0;

   // Result item kinds
   typedef enum logic [1:0] {
      EV_FIELD   = 2'd0,
      EV_DONE    = 2'd1,
      EV_PARTIAL = 2'd2
   } event_kind_type;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_HUNT   = 4'b0001,
      PH_MATCH  = 4'b0010,
      PH_FIELDS = 4'b0100,
      PH_STAR   = 4'b1000
   } phase_type;

   // Result item as it leaves the parser
   typedef struct packed {
      logic          field_overflow;
      logic [9:0]    byte_offset;
      logic [4:0]    field_index;
      event_kind_type event_kind;
   } event_type;

   // Configuration seen by the parser
   typedef struct packed {
      logic [47:0] type_chars;
      logic [2:0]  type_length;
   } cfg_type;

   // Result data packing: field_index, byte_offset, field_overflow
   localparam int RSP_DATA_W   = 16;
   localparam int RSP_OVF_BIT  = 15;

   // Clamp the configured type length to 1 .. MAX_TYPE_CHARS
   function automatic logic [3:0] eff_length(input logic [2:0] len);
      logic [3:0] l;
      l = {1'b0, len};
      if (l == 4'd0) l = 4'd1;
      if (l > 4'(MAX_TYPE_CHARS)) l = 4'(MAX_TYPE_CHARS);
      return l;
   endfunction

   // Type character at a match position; positions past the sixth read zero
   function automatic logic [7:0] type_char(input logic [47:0] chars,
                                            input logic [2:0] k);
      logic [7:0] c;
      c = 8'd0;
      if (k < 3'd6) c = chars[8*k +: 8];
      return c;
   endfunction

endpackage

FILE: rtl/nsfl_parser.sv
// ----------------------------------------------------------------------------
// nsfl_parser: per-byte sentence state and event decode
// Holds the phase, match position, field count, buffer position and overflow
// flag, and decodes one byte per step into at most one event.
// ----------------------------------------------------------------------------
module nsfl_parser
   import nsfl_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024,
   parameter int MAX_FIELDS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_value,
   input  logic       buffer_start,
   input  cfg_type    cfg,
   output logic       ev_valid,
   output event_type  ev
);

   localparam int PW = $clog2(BUFFER_BYTES + 1);
   localparam int FW = $clog2(MAX_FIELDS + 1);
   localparam logic [PW-1:0] POS_END    = PW'(BUFFER_BYTES);
   localparam logic [9:0]    END_OFFSET = 10'(BUFFER_BYTES);

   phase_type       phase_ff, phase_in;
   logic [2:0]      mp_ff, mp_in;
   logic [FW-1:0]   fs_ff, fs_in;
   logic [PW-1:0]   bp_ff, bp_in;
   logic            ovf_ff, ovf_in;

   phase_type       cur;
   logic [PW-1:0]   pos;
   logic [2:0]      mp_next;
   logic [4:0]      close_index;
   logic            open_s;
   logic            past_end;

   // Field count reported at a close saturates at 31
   assign close_index = (int'(fs_ff) > 31) ? 5'd31 : 5'(fs_ff);
   assign mp_next     = mp_ff + 3'd1;
   assign open_s      = (phase_ff == PH_FIELDS) || (phase_ff == PH_STAR);

   // Decode one byte into the next state and an optional event
   always_comb begin
      phase_in = phase_ff;
      mp_in    = mp_ff;
      fs_in    = fs_ff;
      bp_in    = bp_ff;
      ovf_in   = ovf_ff;
      ev_valid = 1'b0;
      ev       = '{field_overflow: ovf_ff, byte_offset: 10'(bp_ff),
                   field_index: close_index, event_kind: EV_PARTIAL};
      cur      = phase_ff;
      pos      = bp_ff;
      past_end = 1'b0;

      // New buffer or end of buffer closes an open sentence
      if (buffer_start) begin
         ev_valid = open_s;
         cur      = PH_HUNT;
         mp_in    = 3'd0;
         pos      = '0;
      end else if (bp_ff >= POS_END) begin
         past_end       = 1'b1;
         ev_valid       = open_s;
         ev.byte_offset = END_OFFSET;
         phase_in       = PH_HUNT;
         mp_in          = 3'd0;
         bp_in          = POS_END;
      end

      if (!past_end) begin
         bp_in    = PW'(pos + 1'b1);
         phase_in = cur;
         unique case (cur)
            PH_HUNT: begin
               if (byte_value == CHAR_DOLLAR) begin
                  phase_in = PH_MATCH;
                  mp_in    = 3'd0;
               end
            end
            PH_MATCH: begin
               if (byte_value == type_char(cfg.type_chars, mp_ff)) begin
                  mp_in = mp_next;
                  if ({1'b0, mp_next} >= eff_length(cfg.type_length)) begin
                     phase_in = PH_FIELDS;
                     fs_in    = '0;
                     ovf_in   = 1'b0;
                  end
               end else if (byte_value == CHAR_DOLLAR) begin
                  mp_in = 3'd0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FIELDS, PH_STAR: begin
               ev.byte_offset = 10'(pos);
               priority if (byte_value == CHAR_CR) begin
                  ev_valid      = 1'b1;
                  ev.event_kind = EV_DONE;
                  phase_in      = PH_HUNT;
               end else if (byte_value == CHAR_NUL) begin
                  ev_valid = 1'b1;
                  phase_in = PH_HUNT;
               end else if (byte_value == CHAR_DOLLAR) begin
                  ev_valid = 1'b1;
                  phase_in = PH_MATCH;
                  mp_in    = 3'd0;
               end else if (cur == PH_FIELDS && byte_value == CHAR_STAR) begin
                  phase_in = PH_STAR;
               end else if (cur == PH_FIELDS && byte_value == CHAR_COMMA) begin
                  if (fs_ff < FW'(MAX_FIELDS)) begin
                     ev_valid = 1'b1;
                     ev       = '{field_overflow: 1'b0,
                                  byte_offset: 10'(PW'(pos + 1'b1)),
                                  field_index: 5'(fs_ff),
                                  event_kind: EV_FIELD};
                     fs_in    = FW'(fs_ff + 1'b1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  // ignore ordinary sentence bytes
                  phase_in = cur;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Advance the sentence state on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         mp_ff    <= 3'd0;
         fs_ff    <= '0;
         bp_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         mp_ff    <= mp_in;
         fs_ff    <= fs_in;
         bp_ff    <= bp_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: rtl/nmea_sentence_field_locator_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_field_locator_unit: NMEA sentence field locator
// Scans a receive buffer byte by byte and reports field starts and sentence
// closes for sentences whose type matches the configured string.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one buffer byte per item in req_tdata, req_tuser high on the
//   first byte of a new buffer (offset restarts at zero).
//   rsp channel: zero or one event per byte: field start (offset just after
//   the comma), sentence complete (carriage return) or sentence incomplete
//   (NUL, new dollar sign, new buffer or buffer end). Keep field starts only
//   for sentences that close complete.
//   csr channel: index 0 writes the type characters (first in lowest byte),
//   index 1 the type length. Write only while the block is idle.
//   With no stall an event becomes valid once its byte has passed the input
//   register and its decode has been loaded into the result register. One
//   byte per cycle is sustained while the rsp channel does not stall; the
//   parser's state update on each consumed byte sets that rate.
//   A stalled rsp channel holds the result register and the input register;
//   req_tready drops only when both are full. Reset empties both registers,
//   returns the parser to hunting at offset zero and restores the csr
//   defaults (no type characters, length five). No clearing pass is needed.
// ----------------------------------------------------------------------------
module nmea_sentence_field_locator_unit
   import nsfl_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024,
   parameter int MAX_FIELDS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] buffer_start
   // events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] field_index, [14:5] byte_offset,
                                    // [15] field_overflow
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [47:0] csr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   event_type   rsp_ev_ff;
   cfg_type     cfg_ff;
   logic        advance;
   logic        step;
   logic        ev_valid;
   event_type   ev;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_chars  <= TYPE_CHARS_RESET;
         cfg_ff.type_length <= TYPE_LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TYPE_CHARS:  cfg_ff.type_chars  <= csr_data;
            CSR_TYPE_LENGTH: cfg_ff.type_length <= csr_data[2:0];
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   // Hold the input item until the parser consumes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   nsfl_parser #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_FIELDS   (MAX_FIELDS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .byte_value   (in_byte_ff),
      .buffer_start (in_start_ff),
      .cfg          (cfg_ff),
      .ev_valid     (ev_valid),
      .ev           (ev)
   );

   // Result register: load on each consumed byte, hold while stalled
   assign rsp_valid_in = advance ? (step && ev_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ev_ff <= ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ev_ff.field_overflow, rsp_ev_ff.byte_offset,
                        rsp_ev_ff.field_index};
   assign rsp_tuser  = rsp_ev_ff.event_kind;

endmodule

FILE: rtl/nsfl_checker.sv
// ----------------------------------------------------------------------------
// nsfl_checker: port-level checks of the field locator
// Watches the handshake and event encoding on the top level ports.
// ----------------------------------------------------------------------------
module nsfl_checker
   import nsfl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled event keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled event changed");

   // No event right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("event valid after reset");

   // Only the three defined event kinds appear
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == EV_FIELD || rsp_tuser == EV_DONE
                      || rsp_tuser == EV_PARTIAL))
      else $error("undefined event kind");

   // Field start events never carry the overflow flag
   a_field_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_FIELD |-> !rsp_tdata[RSP_OVF_BIT])
      else $error("field start with overflow flag");

   // A draining result side never blocks input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while results drain");

endmodule

bind nmea_sentence_field_locator_unit nsfl_checker u_nsfl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/field_locator_checker.sv
// ----------------------------------------------------------------------------
// field_locator_checker: scoreboard for the NMEA sentence field locator
// Watches the csr, req and rsp channels, keeps its own copy of the parser
// state and configuration, predicts the event of every accepted byte and
// compares each accepted event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module field_locator_checker
   import nsfl_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024,
   parameter int MAX_FIELDS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] buffer_start
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [4:0] field_index, [14:5] byte_offset,
                                    // [15] field_overflow
   input  logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [47:0] csr_data,
   output int unsigned predicted_count,
   output int unsigned checked_count,
   output int unsigned error_count,
   output int unsigned start_count,
   output int unsigned done_count,
   output int unsigned partial_count
);

   // Configuration as last written
   logic [47:0] type_str;
   logic [2:0]  type_len;

   // Sentence state
   phase_type   parse_phase;
   logic [2:0]  match_pos;
   int unsigned fields_seen;
   int unsigned buf_pos;
   logic        overflow_seen;

   event_type   expected_events[$];
   int unsigned n_pred, n_chk, n_err, n_field, n_done, n_partial;

   // Queue the close event of the open sentence
   function automatic void close_sentence(input event_kind_type kind,
                                          input int unsigned off);
      event_type e;
      e.event_kind     = kind;
      e.field_index    = (fields_seen > 31) ? 5'd31 : 5'(fields_seen);
      e.byte_offset    = 10'(off);
      e.field_overflow = overflow_seen;
      expected_events.push_back(e);
      n_pred++;
   endfunction

   // Advance the sentence state by one byte and queue what it causes
   function automatic void advance_parser(input logic [7:0] b, input logic first);
      logic        open;
      int unsigned pos;
      int unsigned need;
      logic [7:0]  want;
      event_type   e;
      open = (parse_phase == PH_FIELDS) || (parse_phase == PH_STAR);
      if (first) begin
         if (open) close_sentence(EV_PARTIAL, buf_pos);
         parse_phase = PH_HUNT;
         match_pos   = 3'd0;
         pos         = 0;
      end else begin
         pos = buf_pos;
         // past the buffer end: close once, then ignore until a new buffer
         if (pos >= BUFFER_BYTES) begin
            if (open) close_sentence(EV_PARTIAL, BUFFER_BYTES);
            parse_phase = PH_HUNT;
            match_pos   = 3'd0;
            return;
         end
      end
      buf_pos = pos + 1;

      need = (type_len == 3'd0) ? 1 :
             ((type_len > MAX_TYPE_CHARS) ? MAX_TYPE_CHARS : type_len);
      want = (match_pos < 3'd6) ? type_str[8*match_pos +: 8] : 8'h00;

      case (parse_phase)
         PH_HUNT: begin
            if (b == CHAR_DOLLAR) begin
               parse_phase = PH_MATCH;
               match_pos   = 3'd0;
            end
         end
         PH_MATCH: begin
            if (b == want) begin
               match_pos = match_pos + 3'd1;
               if (match_pos >= need) begin
                  parse_phase   = PH_FIELDS;
                  fields_seen   = 0;
                  overflow_seen = 1'b0;
               end
            end else if (b == CHAR_DOLLAR) begin
               match_pos = 3'd0;
            end else begin
               parse_phase = PH_HUNT;
            end
         end
         default: begin
            if (b == CHAR_CR) begin
               close_sentence(EV_DONE, pos);
               parse_phase = PH_HUNT;
            end else if (b == CHAR_NUL) begin
               close_sentence(EV_PARTIAL, pos);
               parse_phase = PH_HUNT;
            end else if (b == CHAR_DOLLAR) begin
               close_sentence(EV_PARTIAL, pos);
               parse_phase = PH_MATCH;
               match_pos   = 3'd0;
            end else if (parse_phase == PH_FIELDS) begin
               if (b == CHAR_STAR) begin
                  parse_phase = PH_STAR;
               end else if (b == CHAR_COMMA) begin
                  // all slots used: drop the field, flag it at the close
                  if (fields_seen < MAX_FIELDS) begin
                     e.event_kind     = EV_FIELD;
                     e.field_index    = 5'(fields_seen);
                     e.byte_offset    = 10'(pos + 1);
                     e.field_overflow = 1'b0;
                     expected_events.push_back(e);
                     n_pred++;
                     fields_seen++;
                  end else begin
                     overflow_seen = 1'b1;
                  end
               end
            end
         end
      endcase
   endfunction

   // Check events, track register writes, predict accepted bytes
   always @(posedge clock) begin
      event_type want;
      logic      bad;
      if (reset) begin
         type_str      = TYPE_CHARS_RESET;
         type_len      = TYPE_LENGTH_RESET;
         parse_phase   = PH_HUNT;
         match_pos     = 3'd0;
         fields_seen   = 0;
         buf_pos       = 0;
         overflow_seen = 1'b0;
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               n_err++;
               if (n_err <= 10)
                  $display("%0t: unexpected event kind %0d idx %0d off %0d ovf %0d",
                           $time, rsp_tuser, rsp_tdata[4:0], rsp_tdata[14:5],
                           rsp_tdata[15]);
            end else begin
               want = expected_events.pop_front();
               n_chk++;
               bad = (rsp_tuser != want.event_kind) ||
                     (rsp_tdata[4:0] != want.field_index) ||
                     (rsp_tdata[14:5] != want.byte_offset) ||
                     (rsp_tdata[15] != want.field_overflow);
               if (bad) begin
                  n_err++;
                  if (n_err <= 10) begin
                     $display("%0t: event mismatch: got kind %0d idx %0d off %0d ovf %0d",
                              $time, rsp_tuser, rsp_tdata[4:0], rsp_tdata[14:5],
                              rsp_tdata[15]);
                     $display("%0t:    expected kind %0d idx %0d off %0d ovf %0d",
                              $time, want.event_kind, want.field_index,
                              want.byte_offset, want.field_overflow);
                  end
               end
            end
            case (rsp_tuser)
               EV_FIELD: n_field++;
               EV_DONE:  n_done++;
               default:  n_partial++;
            endcase
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TYPE_CHARS) type_str = csr_data;
            else type_len = csr_data[2:0];
         end
         if (req_tvalid && req_tready) advance_parser(req_tdata, req_tuser);
      end
      predicted_count <= n_pred;
      checked_count   <= n_chk;
      error_count     <= n_err;
      start_count     <= n_field;
      done_count      <= n_done;
      partial_count   <= n_partial;
   end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the NMEA sentence field locator
// Feeds receive buffers of generated sentences (matching, mistyped, broken,
// overlong and noise) under several type settings and idle patterns, with
// a long result hold-off and a buffer overrun, and leaves the checking to
// field_locator_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import nsfl_pkg::*;

   localparam int BUFFER_BYTES = 1024;
   localparam int MAX_FIELDS   = 32;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 85;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 500000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [47:0] csr_data;

   int unsigned predicted_count, checked_count, error_count;
   int unsigned start_count, done_count, partial_count;

   // Stimulus state
   logic [47:0] cur_chars;
   logic [2:0]  cur_len;
   int unsigned buf_fill;
   int unsigned buf_limit;
   int unsigned items_sent;
   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned hold_asked;
   int unsigned cycle_count;
   logic [47:0] phase_chars[NUM_PHASES];
   logic [2:0]  phase_len[NUM_PHASES];

   nmea_sentence_field_locator_unit #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .MAX_FIELDS  (MAX_FIELDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   field_locator_checker #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .MAX_FIELDS  (MAX_FIELDS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .predicted_count(predicted_count),
      .checked_count  (checked_count),
      .error_count    (error_count),
      .start_count    (start_count),
      .done_count     (done_count),
      .partial_count  (partial_count)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if it hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d events outstanding", cycle_count,
               predicted_count - checked_count);
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin
      int unsigned hold_served;
      int unsigned hold_left;
      hold_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served++;
            rsp_tready <= 1'b0;
            for (hold_left = HOLD_CYCLES - 1; hold_left > 0; hold_left--)
               @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one byte and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a buffer byte; start a new buffer when the current one is full
   task automatic feed(input logic [7:0] b);
      logic first;
      first = 1'b0;
      if (buf_fill >= buf_limit ||
          (buf_limit < BUFFER_BYTES && $urandom_range(299) == 0)) begin
         first     = 1'b1;
         buf_fill  = 0;
         buf_limit = $urandom_range(400, 60);
      end
      if (buf_fill < BUFFER_BYTES) items_sent++;
      buf_fill++;
      send_byte(b, first);
   endtask

   // Drop valid and wait until every predicted event has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_count != checked_count);
      repeat (8) @(posedge clock);
   endtask

   // Write both type registers while the block is idle
   task automatic set_type(input logic [47:0] chars, input logic [2:0] len);
      csr_valid <= 1'b1;
      csr_index <= CSR_TYPE_CHARS;
      csr_data  <= chars;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_TYPE_LENGTH;
      csr_data  <= {45'd0, len};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_chars = chars;
      cur_len   = len;
   endtask

   function automatic int unsigned type_span();
      if (cur_len == 3'd0) return 1;
      if (cur_len > MAX_TYPE_CHARS) return MAX_TYPE_CHARS;
      return cur_len;
   endfunction

   // Dollar sign and sentence type, optionally with one wrong character
   task automatic open_sentence(input bit corrupt);
      int unsigned span;
      int unsigned bad_at;
      int unsigned k;
      logic [7:0]  c;
      span   = type_span();
      bad_at = corrupt ? $urandom_range(span - 1) : span;
      feed(CHAR_DOLLAR);
      for (k = 0; k < span; k++) begin
         c = cur_chars[8*k +: 8];
         if (k == bad_at) c = ($urandom_range(3) == 0) ? CHAR_DOLLAR : 8'($urandom);
         feed(c);
      end
   endtask

   // One sentence: type, fields, then a random ending
   task automatic send_sentence();
      int unsigned nf;
      int unsigned tail;
      int unsigned i;
      open_sentence($urandom_range(99) < 12);
      nf = ($urandom_range(15) == 0) ? $urandom_range(40, 33) : $urandom_range(10);
      for (i = 0; i < nf; i++) begin
         feed(CHAR_COMMA);
         repeat ($urandom_range(5)) begin
            feed(($urandom_range(7) == 0) ? "." : 8'($urandom_range(8'h5A, 8'h30)));
         end
      end
      tail = $urandom_range(99);
      if (tail < 60) begin
         // checksum then line end; a comma after the star is ignored
         feed(CHAR_STAR);
         if ($urandom_range(3) == 0) feed(CHAR_COMMA);
         feed(8'($urandom_range(8'h39, 8'h30)));
         feed(8'($urandom_range(8'h46, 8'h41)));
         feed(CHAR_CR);
         feed(8'h0A);
      end else if (tail < 72) begin
         feed(CHAR_CR);
         feed(8'h0A);
      end else if (tail < 82) begin
         feed(CHAR_NUL);
      end else if (tail < 95) begin
         // leave open, with or without the star; the next dollar closes it
         if (tail >= 90) feed(CHAR_STAR);
      end else begin
         feed(CHAR_STAR);
         feed(CHAR_NUL);
      end
   endtask

   // Stimulus and verdict
   initial begin
      int p;
      int unsigned phase_end;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TYPE_CHARS;
      csr_data   <= 48'd0;
      cur_chars  = TYPE_CHARS_RESET;
      cur_len    = TYPE_LENGTH_RESET;
      buf_fill   = 0;
      buf_limit  = 0;
      items_sent = 0;
      gap_pct    = 0;
      stall_pct  = 0;
      hold_asked = 0;

      phase_chars[0] = 48'h0041_4747_5047;            // GPGGA
      phase_len[0]   = 3'd5;
      phase_chars[1] = 48'hA5C3_0F00_5A47;            // G, upper bytes unused
      phase_len[1]   = 3'd1;
      phase_chars[2] = 48'({$urandom, $urandom});
      phase_len[2]   = 3'd6;
      phase_chars[3] = 48'hFFFF_FFFF_FFFF;
      phase_len[3]   = 3'd7;                          // clamps to six
      phase_chars[4] = 48'h0000_0000_4E47;            // GN
      phase_len[4]   = 3'd0;                          // acts as one
      phase_chars[5] = 48'h0000_0000_0000;
      phase_len[5]   = 3'd3;
      phase_chars[6] = 48'h0043_4D52_5047;            // GPRMC
      phase_len[6]   = 3'd5;
      phase_chars[7] = 48'({$urandom, $urandom});
      phase_len[7]   = 3'($urandom_range(7));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: the type is five NUL characters
      feed(CHAR_DOLLAR);
      repeat (5) feed(CHAR_NUL);
      feed(CHAR_CR);
      wait_idle();

      set_type(48'h0000_0000_4E47, 3'd2);
      // mismatch on a dollar restarts the match, NUL closes incomplete
      buf_limit = 0;
      feed(CHAR_DOLLAR); feed("G"); feed(CHAR_DOLLAR); feed("G"); feed("N");
      feed(CHAR_COMMA); feed(CHAR_NUL);
      // bytes after the star are ignored up to the carriage return
      feed(CHAR_DOLLAR); feed("G"); feed("N"); feed(CHAR_COMMA);
      feed(CHAR_STAR); feed("x"); feed(CHAR_COMMA); feed(CHAR_CR);
      // new buffer in mid-sentence
      feed(CHAR_DOLLAR); feed("G"); feed("N"); feed(CHAR_COMMA);
      buf_limit = 0;
      feed(8'hFF);
      wait_idle();

      for (p = 0; p < NUM_PHASES; p++) begin
         set_type(phase_chars[p], phase_len[p]);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 11; stall_pct = 11; end
         endcase
         phase_end = items_sent + PHASE_ITEMS;

         // hold results off while a comma burst fills the block
         if (p == 0 || p == 5) begin
            hold_asked++;
            open_sentence(1'b0);
            repeat (24) feed(CHAR_COMMA);
            feed(CHAR_CR);
         end

         // run one buffer past its end with a sentence still open
         if (p == 2) begin
            buf_limit = 0;
            feed(8'h0A);
            buf_limit = 2000;
            while (buf_fill < 990) send_sentence();
            open_sentence(1'b0);
            while (buf_fill < 1040) feed(CHAR_COMMA);
            buf_limit = 0;
         end

         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 30) begin
               repeat ($urandom_range(4, 1)) feed(8'($urandom));
            end
            send_sentence();
         end
         wait_idle();
      end

      $display("Bytes sent: %0d over %0d type settings; events checked: %0d",
               items_sent, NUM_PHASES + 2, checked_count);
      $display("Field starts %0d, complete %0d, incomplete %0d, mismatches %0d",
               start_count, done_count, partial_count, error_count);
      if (error_count == 0 && predicted_count == checked_count)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
